// ===== hdl/crs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crs_pkg
// Shared types and constants of the chunk request splitter: payload structs,
// controller states, command and status groups, register indexes and widths.
// ============================================================================
package crs_pkg;

    localparam int OFF_W     = 32;
    localparam int SIZE_W    = 32;
    localparam int BUF_W     = 64;
    localparam int PAGE_W    = 40;
    localparam int PSIZE_W   = 16;
    localparam int WIDX_W    = 6;
    localparam int PCOUNT_W  = 7;
    localparam int CS_W      = 16;
    localparam int WC_W      = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 1'd1;

    localparam logic [CS_W-1:0] CHUNK_SIZE_RESET   = 16'd4096;
    localparam logic [WC_W-1:0] WORKER_COUNT_RESET = 7'd1;
    localparam logic [WC_W-1:0] WORKER_COUNT_MAX   = 7'd64;

    localparam int MAX_PIECES_DEF = 64;

    // All dividends are zero-extended to the page width so that the chunk
    // divisions and the worker modulo chains run in lockstep.
    localparam int DIV_STEPS = PAGE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [OFF_W-1:0]  file_offset;
        logic [SIZE_W-1:0] request_size;
        logic [BUF_W-1:0]  buffer_address;
        logic [PAGE_W-1:0] base_page;
    } in_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_number;
        logic [OFF_W-1:0]    piece_offset;
        logic [PSIZE_W-1:0]  piece_size;
        logic [BUF_W-1:0]    piece_buffer;
        logic [WIDX_W-1:0]   worker_index;
        logic [PCOUNT_W-1:0] piece_count;
        logic                last_piece;
        logic                error_flag;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic piece_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/crs_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crs_ctrl
// Sequencer of the splitter: accepts a request, runs the division steps,
// a setup cycle, then one piece per free output slot until the last piece.
// ============================================================================
module crs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  crs_pkg::sts_t sts,
    output crs_pkg::cmd_t cmd
);
    import crs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free && sts.piece_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/crs_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crs_datapath
// Configuration registers, the two restoring chunk dividers, the worker
// modulo chains, the piece generator and the output register.
// ============================================================================
module crs_datapath #(
    parameter int MAX_PIECES = crs_pkg::MAX_PIECES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  crs_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output crs_pkg::out_t                  m_data,
    input  crs_pkg::cmd_t                  cmd,
    output crs_pkg::sts_t                  sts
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIECES + 1);

    // Configuration
    logic [CS_W-1:0] cs_reg;
    logic [WC_W-1:0] wc_reg;
    logic [WC_W-1:0] wce;

    // Request and division state
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [OFF_W:0]     end_reg, end_next;
    logic               zero_size_reg, zero_size_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [PAGE_W-1:0]  base_reg, base_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CS_W-1:0]    rem1_reg, rem1_next;
    logic [CS_W-1:0]    rem2_reg, rem2_next;
    logic [PAGE_W-1:0]  q1_reg, q1_next;
    logic [PAGE_W-1:0]  q2_reg, q2_next;
    logic [WIDX_W-1:0]  rb_reg, rb_next;
    logic [WIDX_W-1:0]  rq_reg, rq_next;
    logic [WIDX_W-1:0]  rp_reg, rp_next;

    // Piece generation state
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [WIDX_W-1:0]  wi_reg, wi_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               err_reg, err_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    // Combinational helpers
    logic [STEP_W-1:0]  bit_idx;
    logic [PAGE_W-1:0]  off_ext, end_ext;
    logic [CS_W:0]      t1, t2;
    logic               ge1, ge2;
    logic [WC_W-1:0]    tb, tq, tp;
    logic [PAGE_W:0]    page_sum;
    logic [PAGE_W-1:0]  count_full;
    logic               setup_err;
    logic [WC_W-1:0]    ws, ws1;
    logic               k_first, k_last;
    logic [PSIZE_W-1:0] psize;
    out_t               piece;

    assign wce = (wc_reg == '0) ? WC_W'(1) :
                 (wc_reg > WORKER_COUNT_MAX) ? WORKER_COUNT_MAX : wc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg <= CHUNK_SIZE_RESET;
            wc_reg <= WORKER_COUNT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_CHUNK_SIZE) begin
                cs_reg <= cfg_wdata[CS_W-1:0];
            end
            if (cfg_index == REG_WORKER_COUNT) begin
                wc_reg <= cfg_wdata[WC_W-1:0];
            end
        end
    end

    // One restoring step per cycle for each divider, quotient bits MSB first.
    assign bit_idx = STEP_W'(DIV_STEPS - 1) - step_reg;
    assign off_ext = PAGE_W'(off_reg);
    assign end_ext = PAGE_W'(end_reg);
    assign t1  = {rem1_reg, off_ext[bit_idx]};
    assign t2  = {rem2_reg, end_ext[bit_idx]};
    assign ge1 = t1 >= {1'b0, cs_reg};
    assign ge2 = t2 >= {1'b0, cs_reg};

    // Residues mod the worker count: the base page, the start chunk as its
    // quotient bits arrive, and 2^40 for a page number that wraps.
    assign tb = {rb_reg, base_reg[bit_idx]};
    assign tq = {rq_reg, ge1};
    assign tp = {rp_reg, 1'b0};

    assign page_sum   = {1'b0, base_reg} + {1'b0, q1_reg};
    assign count_full = q2_reg - q1_reg + PAGE_W'(1);
    assign setup_err  = zero_size_reg || (cs_reg == '0) ||
                        (count_full > PAGE_W'(MAX_PIECES));

    always_comb begin
        ws  = WC_W'(rb_reg) + WC_W'(rq_reg);
        ws1 = (ws >= wce) ? (ws - wce) : ws;
        if (page_sum[PAGE_W]) begin
            ws1 = (ws1 >= WC_W'(rp_reg)) ? (ws1 - WC_W'(rp_reg))
                                          : (ws1 + wce - WC_W'(rp_reg));
        end
    end

    // The last piece ends at the remainder of the end byte; a single piece
    // spans both remainders.
    assign k_first = (k_reg == '0);
    assign k_last  = (k_reg == count_reg - CNT_W'(1));

    always_comb begin
        if (k_first && k_last) begin
            psize = rem2_reg - rem1_reg + PSIZE_W'(1);
        end else if (k_first) begin
            psize = cs_reg - rem1_reg;
        end else if (k_last) begin
            psize = rem2_reg + PSIZE_W'(1);
        end else begin
            psize = cs_reg;
        end
    end

    always_comb begin
        piece = '0;
        piece.last_piece = 1'b1;
        piece.error_flag = 1'b1;
        if (!err_reg) begin
            piece.page_number  = page_reg;
            piece.piece_offset = off_reg;
            piece.piece_size   = psize;
            piece.piece_buffer = buf_reg;
            piece.worker_index = wi_reg;
            piece.piece_count  = PCOUNT_W'(count_reg);
            piece.last_piece   = k_last;
            piece.error_flag   = 1'b0;
        end
    end

    always_comb begin
        off_next       = off_reg;
        end_next       = end_reg;
        zero_size_next = zero_size_reg;
        buf_next       = buf_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        rem1_next      = rem1_reg;
        rem2_next      = rem2_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        rb_next        = rb_reg;
        rq_next        = rq_reg;
        rp_next        = rp_reg;
        page_next      = page_reg;
        wi_next        = wi_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (cmd.load) begin
            off_next       = s_data.file_offset;
            end_next       = {1'b0, s_data.file_offset} + {1'b0, s_data.request_size}
                             - (OFF_W + 1)'(1);
            zero_size_next = (s_data.request_size == '0);
            buf_next       = s_data.buffer_address;
            base_next      = s_data.base_page;
            step_next      = '0;
            rem1_next      = '0;
            rem2_next      = '0;
            q1_next        = '0;
            q2_next        = '0;
            rb_next        = '0;
            rq_next        = '0;
            rp_next        = (wce == WC_W'(1)) ? WIDX_W'(0) : WIDX_W'(1);
        end

        if (cmd.step) begin
            step_next = step_reg + STEP_W'(1);
            rem1_next = ge1 ? CS_W'(t1 - {1'b0, cs_reg}) : t1[CS_W-1:0];
            rem2_next = ge2 ? CS_W'(t2 - {1'b0, cs_reg}) : t2[CS_W-1:0];
            q1_next   = {q1_reg[PAGE_W-2:0], ge1};
            q2_next   = {q2_reg[PAGE_W-2:0], ge2};
            rb_next   = (tb >= wce) ? WIDX_W'(tb - wce) : tb[WIDX_W-1:0];
            rq_next   = (tq >= wce) ? WIDX_W'(tq - wce) : tq[WIDX_W-1:0];
            rp_next   = (tp >= wce) ? WIDX_W'(tp - wce) : tp[WIDX_W-1:0];
        end

        if (cmd.setup) begin
            page_next  = page_sum[PAGE_W-1:0];
            wi_next    = ws1[WIDX_W-1:0];
            count_next = count_full[CNT_W-1:0];
            k_next     = '0;
            err_next   = setup_err;
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = piece;
            k_next       = k_reg + CNT_W'(1);
            page_next    = page_reg + PAGE_W'(1);
            off_next     = off_reg + OFF_W'(psize);
            buf_next     = buf_reg + BUF_W'(psize);
            // A page number that wraps to zero restarts the worker rotation.
            if (page_reg == '1 || WC_W'(wi_reg) == wce - WC_W'(1)) begin
                wi_next = '0;
            end else begin
                wi_next = wi_reg + WIDX_W'(1);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg       <= off_next;
        end_reg       <= end_next;
        zero_size_reg <= zero_size_next;
        buf_reg       <= buf_next;
        base_reg      <= base_next;
        step_reg      <= step_next;
        rem1_reg      <= rem1_next;
        rem2_reg      <= rem2_next;
        q1_reg        <= q1_next;
        q2_reg        <= q2_next;
        rb_reg        <= rb_next;
        rq_reg        <= rq_next;
        rp_reg        <= rp_next;
        page_reg      <= page_next;
        wi_reg        <= wi_next;
        count_reg     <= count_next;
        k_reg         <= k_next;
        err_reg       <= err_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.div_done   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign sts.piece_last = err_reg || k_last;
    assign sts.out_free   = !m_valid_reg || m_ready;

    a_emit_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("piece written over an untaken result");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.setup |=> (err_reg || count_reg != '0))
        else $error("request set up with no pieces and no error");

    a_piece_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !err_reg) |-> (k_reg < count_reg))
        else $error("piece index beyond piece count");

    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.error_flag) |->
            (m_data_reg.last_piece && m_data_reg.piece_count == '0))
        else $error("error result is not a lone final result");

endmodule

// ===== hdl/chunk_request_splitter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chunk_request_splitter
// Splits a byte-range request into one piece per chunk of chunk_size bytes,
// each with its page number, offset, size, buffer address and worker index.
// ============================================================================
//
//  Channel   | Dir | Handshake               | Content
//  ----------+-----+-------------------------+-----------------------------
//  s_        | in  | s_valid / s_ready       | in_t: one request
//  m_        | out | m_valid / m_ready       | out_t: one piece or an error
//  cfg_      | in  | cfg_we (no wait)        | cfg_index, cfg_wdata
//
//  A request passes through the accept step, 40 steps of the shared-sequence
//  chunk dividers and worker modulo chains (one bit of the 40-bit page width
//  each), a setup step, then one piece per cycle while the output register
//  is free, up to the last piece or a lone error result.
//  Reset is synchronous and active low; it sets chunk_size to 4096 and
//  worker_count to 1 and empties the output register.
//  A low m_ready holds the current piece in the output register and stalls
//  piece generation; the next request is accepted while the last piece waits.
//
module chunk_request_splitter #(
    parameter int MAX_PIECES = crs_pkg::MAX_PIECES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  crs_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output crs_pkg::out_t                  m_data
);
    import crs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    crs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crs_datapath #(
        .MAX_PIECES (MAX_PIECES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== verif/crs_piece_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crs_piece_checker
// Watches the register port and both request channels of the chunk request
// splitter. It works out the pieces of every accepted request and checks,
// field by field and in order, each piece that leaves the block.
// ============================================================================
module crs_piece_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  crs_pkg::in_t                   s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  crs_pkg::out_t                  m_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             pieces_seen,
    output int                             error_results
);
    import crs_pkg::*;

    localparam int PRINT_LIMIT = 40;

    logic [CS_W-1:0] chunk_bytes;
    logic [WC_W-1:0] workers;
    out_t            pieces_due [$];
    out_t            want;

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        pieces_seen   = 0;
        error_results = 0;
        chunk_bytes   = CHUNK_SIZE_RESET;
        workers       = WORKER_COUNT_RESET;
    end

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns  piece %0d: %s", $time, pieces_seen, what);
    endtask

    // Appends one piece at the tail of the expected sequence.
    task automatic enqueue_piece(input out_t p);
        pieces_due = {pieces_due, p};
    endtask

    // Works out every piece of one request and queues them in output order.
    task automatic split_request(input in_t req);
        longint unsigned cs, wc, off, size, first_chunk, count, done, psize, k;
        logic [PAGE_W-1:0] page;
        out_t piece;
        cs   = chunk_bytes;
        wc   = workers;
        off  = req.file_offset;
        size = req.request_size;
        if (wc == 0)
            wc = 1;
        if (wc > WORKER_COUNT_MAX)
            wc = WORKER_COUNT_MAX;
        count = 0;
        first_chunk = 0;
        if (size != 0 && cs != 0) begin
            first_chunk = off / cs;
            count = (off + size - 1) / cs - first_chunk + 1;
        end
        // Zero size, zero chunk size and an overlong span all give one flagged result.
        if (count == 0 || count > MAX_PIECES_DEF) begin
            piece = '0;
            piece.last_piece = 1'b1;
            piece.error_flag = 1'b1;
            enqueue_piece(piece);
            return;
        end
        done = 0;
        for (k = 0; k < count; k++) begin
            page = PAGE_W'(req.base_page + first_chunk + k);
            if (k == 0)
                psize = (size + off % cs > cs) ? cs - off % cs : size;
            else if (k == count - 1)
                psize = size - done;
            else
                psize = cs;
            piece.page_number  = page;
            piece.piece_offset = OFF_W'(off + done);
            piece.piece_size   = PSIZE_W'(psize);
            piece.piece_buffer = req.buffer_address + done;
            piece.worker_index = WIDX_W'(page % wc);
            piece.piece_count  = PCOUNT_W'(count);
            piece.last_piece   = (k == count - 1);
            piece.error_flag   = 1'b0;
            enqueue_piece(piece);
            done += psize;
        end
    endtask

    task automatic compare_piece(input out_t got, input out_t exp_piece);
        if (got.page_number !== exp_piece.page_number)
            report($sformatf("page_number %h, expected %h",
                             got.page_number, exp_piece.page_number));
        if (got.piece_offset !== exp_piece.piece_offset)
            report($sformatf("piece_offset %h, expected %h",
                             got.piece_offset, exp_piece.piece_offset));
        if (got.piece_size !== exp_piece.piece_size)
            report($sformatf("piece_size %h, expected %h",
                             got.piece_size, exp_piece.piece_size));
        if (got.piece_buffer !== exp_piece.piece_buffer)
            report($sformatf("piece_buffer %h, expected %h",
                             got.piece_buffer, exp_piece.piece_buffer));
        if (got.worker_index !== exp_piece.worker_index)
            report($sformatf("worker_index %0d, expected %0d",
                             got.worker_index, exp_piece.worker_index));
        if (got.piece_count !== exp_piece.piece_count)
            report($sformatf("piece_count %0d, expected %0d",
                             got.piece_count, exp_piece.piece_count));
        if (got.last_piece !== exp_piece.last_piece)
            report($sformatf("last_piece %b, expected %b",
                             got.last_piece, exp_piece.last_piece));
        if (got.error_flag !== exp_piece.error_flag)
            report($sformatf("error_flag %b, expected %b",
                             got.error_flag, exp_piece.error_flag));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            chunk_bytes = CHUNK_SIZE_RESET;
            workers     = WORKER_COUNT_RESET;
            pieces_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHUNK_SIZE:   chunk_bytes = cfg_wdata[CS_W-1:0];
                    REG_WORKER_COUNT: workers = cfg_wdata[WC_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                split_request(s_data);
            if (m_valid && m_ready) begin
                pieces_seen++;
                if (pieces_due.size() == 0) begin
                    report("piece arrived with nothing expected");
                end else begin
                    want = pieces_due.pop_front();
                    if (want.error_flag)
                        error_results++;
                    compare_piece(m_data, want);
                end
            end
        end
        outstanding = pieces_due.size();
    end

endmodule

// ===== verif/chunk_request_splitter_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chunk_request_splitter_tb
// Sends directed and random byte-range requests through the chunk request
// splitter under several chunk size and worker count settings, with random
// gaps on the input and random stalls on the output. The piece checker
// beside the block predicts and compares every piece.
// ============================================================================
module chunk_request_splitter_tb;
    import crs_pkg::*;

    localparam int                TIMEOUT_NS = 20_000_000;
    localparam int                LONG_HOLD  = 400;
    localparam logic [PAGE_W-1:0] PAGE_TOP   = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;

    int mismatches, outstanding, pieces_seen, error_results;
    int requests_sent = 0;
    int settings_used = 1;   // the reset values are the first setting
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_asks     = 0;
    int hold_served   = 0;

    always #4 aclk = ~aclk;

    chunk_request_splitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    crs_piece_checker piece_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .pieces_seen   (pieces_seen),
        .error_results (error_results)
    );

    // Mostly short gaps, some medium, a few long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return $urandom_range(3, 1);
        if (pick < 95)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic in_t make_request(input logic [OFF_W-1:0] off,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [BUF_W-1:0] buf_addr,
                                         input logic [PAGE_W-1:0] page);
        in_t r;
        r.file_offset    = off;
        r.request_size   = size;
        r.buffer_address = buf_addr;
        r.base_page      = page;
        return r;
    endfunction

    // Picks a span in chunks first and then a size that gives exactly that span,
    // so most requests are well formed; the rest are zero, huge or overlong.
    function automatic in_t random_request(input int unsigned cs);
        int unsigned     pick;
        longint unsigned n, c, in_chunk, lo, hi;
        in_t             r;
        r.buffer_address = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            r.base_page = PAGE_TOP - $urandom_range(70);
        else
            r.base_page = PAGE_W'({$urandom, $urandom});
        if ($urandom_range(7) == 0)
            r.file_offset = 32'hFFFF_FFFF - $urandom_range(200000);
        else
            r.file_offset = $urandom;
        pick = $urandom_range(99);
        if (pick >= 88)
            n = $urandom_range(70, 65);
        else if (pick < 20)
            n = $urandom_range(64, 9);
        else
            n = $urandom_range(8, 1);
        c = cs;
        if (c == 0) begin
            r.request_size = $urandom_range(5000, 1);
        end else begin
            in_chunk = r.file_offset % c;
            lo = (n == 1) ? 1 : (n - 1) * c - in_chunk + 1;
            hi = n * c - in_chunk;
            r.request_size = SIZE_W'(lo + {$urandom, $urandom} % (hi - lo + 1));
        end
        if (pick >= 95)
            r.request_size = '0;
        else if (pick >= 91)
            r.request_size = $urandom;
        return r;
    endfunction

    task automatic idle_input(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic offer(input in_t r);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if ($urandom_range(99) < tx_idle_pct)
            idle_input(idle_length());
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] cs_word,
                              input logic [CFG_DATA_W-1:0] wc_word);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHUNK_SIZE;
        cfg_wdata <= cs_word;
        @(negedge aclk);
        cfg_index <= REG_WORKER_COUNT;
        cfg_wdata <= wc_word;
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cs_word,
                             input logic [CFG_DATA_W-1:0] wc_word,
                             input int count, input int tx_pct, input int rx_pct);
        drain();
        set_config(cs_word, wc_word);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            offer(random_request(cs_word));
            // Halfway through, the sender waits until every piece is back.
            if (i == count / 2)
                drain();
        end
    endtask

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_served) begin
                // Long hold-off so that the block fills up and stalls its input.
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_served++;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(99) < rx_stall_pct)
                    stall_left = idle_length();
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset values: 4096-byte chunks, one worker.
        tx_idle_pct  = 30;
        rx_stall_pct = 20;
        offer(make_request(32'd0, 32'd0, 64'd0, 40'd0));
        offer(make_request(32'd0, 32'd1, '1, '0));
        offer(make_request(32'd0, 32'd4096, 64'h1000, 40'd5));
        offer(make_request(32'd4095, 32'd2, 64'h10, 40'd7));
        offer(make_request(32'd100, 32'(3 * 4096), 64'hDEAD_0000, 40'h12_3456_789A));
        offer(make_request(32'd0, 32'(64 * 4096), 64'd0, 40'd0));
        offer(make_request(32'd1, 32'(64 * 4096), 64'd0, 40'd0));
        offer(make_request(32'd0, 32'hFFFF_FFFF, '1, '1));
        offer(make_request(32'hFFFF_FFFF, 32'd1, 64'd0, 40'd0));
        offer(make_request(32'hFFFF_F000, 32'h2000, 64'd0, 40'd3));
        offer(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
        offer(make_request(32'd0, 32'(3 * 4096), 64'd0, PAGE_TOP));
        offer(make_request(32'd10, 32'd8192, 64'hFFFF_FFFF_FFFF_F000, 40'd1));
        offer(make_request(32'h8000_0000, 32'd4096, 64'h8000_0000_0000_0000,
                           40'h80_0000_0000));
        offer(make_request(32'hFFFF_0000, 32'(63 * 4096 + 1), 64'h5555_AAAA_5555_AAAA,
                           40'h55_AAAA_5555));
        offer(make_request(32'(5 * 4096 - 1), 32'd1, 64'h1, 40'h1));

        // The receiver holds off for a long stretch while requests keep coming.
        tx_idle_pct = 0;
        hold_asks++;
        repeat (8) offer(random_request(CHUNK_SIZE_RESET));

        run_phase(16'd1, 16'd64, 22, 25, 25);
        run_phase(16'd65535, 16'd1, 22, 10, 40);
        run_phase(16'd0, 16'd0, 8, 30, 10);
        run_phase(16'd7, 16'd0, 22, 0, 0);
        run_phase(16'd100, 16'd127, 22, 40, 30);
        run_phase(16'($urandom_range(65535, 1)), 16'($urandom_range(64, 1)), 22, 20, 20);
        run_phase(16'd512, 16'hFFC0, 22, 15, 15);

        drain();
        repeat (60) @(negedge aclk);
        $display("summary: %0d requests under %0d register settings, %0d pieces checked",
                 requests_sent, settings_used, pieces_seen);
        $display("summary: %0d error results, %0d mismatches", error_results, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
